// ----- rtl/salc_pkg.sv -----
// salc_pkg: shared types, codes and constants of the set-associative LRU cache model
// used by salc_upd and set_assoc_lru_cache_sim; no dependencies
package salc_pkg;

  // field widths
  localparam int TAG_W        = 62;
  localparam int RANK_W       = 3;
  localparam int OP_W         = 2;
  localparam int ADDR_W       = 64;
  localparam int OUTCOME_W    = 2;
  localparam int TOTAL_W      = 32;
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int LINE_W       = TAG_W + 1 + RANK_W;

  // default sizing
  localparam int MAX_SETS_DEF = 64;
  localparam int MAX_WAYS_DEF = 8;

  // rank saturation
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  // operation codes
  localparam logic [OP_W-1:0] OP_FETCH  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd2;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd3;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MISS    = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT   = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_IGNORED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

  // configuration reset values
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;

  // one cache line as held in a set row
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              vld;
    logic [RANK_W-1:0] rank;
  } line_t;

  // lookup result flags
  typedef struct packed {
    logic hit;
    logic evict;
  } upd_res_t;

  // largest n with 2^n not above x
  function automatic int flog2(input int x);
    int n;
    n = 0;
    while ((n < 31) && ((64'd1 << (n + 1)) <= 64'(x))) begin
      n = n + 1;
    end
    return n;
  endfunction

endpackage

// ----- rtl/salc_ram.sv -----
// salc_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/salc_upd.sv -----
// salc_upd: tag compare, fill/victim choice and LRU rank update of one set row
// depends on salc_pkg
module salc_upd #(
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  salc_pkg::line_t [MAX_WAYS-1:0]   row_i,
  input  logic [salc_pkg::TAG_W-1:0]       tag_i,
  input  logic [MAX_WAYS-1:0]              in_use_i,
  output salc_pkg::line_t [MAX_WAYS-1:0]   row_o,
  output salc_pkg::upd_res_t               res_o
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0]         hit_vec;
  logic [MAX_WAYS-1:0]         free_vec;
  logic [WAY_W-1:0]            hit_way;
  logic [WAY_W-1:0]            free_way;
  logic [WAY_W-1:0]            victim_way;
  logic [WAY_W-1:0]            pick_way;
  logic [salc_pkg::RANK_W-1:0] best_rank;
  logic [salc_pkg::RANK_W-1:0] hit_rank;
  logic                        any_hit;
  logic                        any_free;

  // per-way match and free flags
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w]  = in_use_i[w] && row_i[w].vld && (row_i[w].tag == tag_i);
      free_vec[w] = in_use_i[w] && !row_i[w].vld;
    end
  end

  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;

  // lowest-numbered matching and free ways
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // victim: largest rank, lowest way on a tie
  always_comb begin
    best_rank  = row_i[0].rank;
    victim_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use_i[w] && (row_i[w].rank > best_rank)) begin
        best_rank  = row_i[w].rank;
        victim_way = WAY_W'(w);
      end
    end
  end

  assign pick_way = any_free ? free_way : victim_way;
  assign hit_rank = row_i[hit_way].rank;

  // new row contents
  always_comb begin
    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (any_hit) begin
        if ((WAY_W'(w) == hit_way)) begin
          row_o[w].rank = '0;
        end else if (in_use_i[w] && row_i[w].vld && (row_i[w].rank < hit_rank)
                     && (row_i[w].rank != salc_pkg::RANK_MAX)) begin
          row_o[w].rank = row_i[w].rank + 1'b1;
        end
      end else begin
        if (WAY_W'(w) == pick_way) begin
          row_o[w].tag  = tag_i;
          row_o[w].vld  = 1'b1;
          row_o[w].rank = '0;
        end else if (in_use_i[w] && row_i[w].vld
                     && (row_i[w].rank != salc_pkg::RANK_MAX)) begin
          row_o[w].rank = row_i[w].rank + 1'b1;
        end
      end
    end
  end

  assign res_o.hit   = any_hit;
  assign res_o.evict = !any_hit && !any_free;

endmodule

// ----- rtl/set_assoc_lru_cache_sim.sv -----
// Set-associative cache model with true LRU replacement. An item accepted in ST_IDLE
// reads the set's row (tags, valid bits, ranks of all ways) from a synchronous RAM
// with a registered read port; in ST_LOOKUP, once the output register is free, the row
// is compared, updated and written back and the result is loaded. No new item is taken
// until the last one leaves ST_LOOKUP. A single row access serves each item; a modify
// completes in the same pass because its second access always hits the line just
// touched. Instruction fetches pass through the same states with no update. After
// reset a clearing pass zeroes every row of the row memory, during which no item is
// accepted. Configuration writes are taken at any time but are meant for idle periods.
// Totals saturate at 2^32-1. Depends on salc_pkg, salc_ram and salc_upd.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // trace items in
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [salc_pkg::OP_W-1:0]          op_i,
  input  logic [salc_pkg::ADDR_W-1:0]        address_i,
  // results out
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [salc_pkg::OUTCOME_W-1:0]     outcome_o,
  output logic                               second_hit_o,
  output logic [salc_pkg::TOTAL_W-1:0]       hit_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]       miss_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]       eviction_total_o
);

  localparam int IDX_W   = $clog2(MAX_SETS);
  localparam int SET_LIM = salc_pkg::flog2(MAX_SETS);
  localparam int NW_W    = $clog2(MAX_WAYS + 1);
  localparam int ROW_W   = MAX_WAYS * salc_pkg::LINE_W;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [IDX_W-1:0]                  clr_cnt_q;
  logic [salc_pkg::SET_BITS_W-1:0]   set_bits_q;
  logic [salc_pkg::WAYS_W-1:0]       ways_q;
  logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_q;

  logic [salc_pkg::OP_W-1:0]         op_q;
  logic [salc_pkg::TAG_W-1:0]        tag_q;
  logic [IDX_W-1:0]                  set_q;

  logic                              out_valid_q;
  logic [salc_pkg::OUTCOME_W-1:0]    outcome_q;
  logic                              second_q;
  logic [salc_pkg::TOTAL_W-1:0]      hits_q, misses_q, evicts_q;
  logic [salc_pkg::TOTAL_W-1:0]      hits_d, misses_d, evicts_d;

  logic [salc_pkg::BLOCK_BITS_W-1:0] bb_eff;
  logic [salc_pkg::SET_BITS_W-1:0]   sb_eff;
  logic [NW_W-1:0]                   nw_eff;
  logic [MAX_WAYS-1:0]               in_use;
  logic [salc_pkg::ADDR_W-1:0]       addr_sh;
  logic [salc_pkg::ADDR_W-1:0]       tag_full;
  logic [IDX_W-1:0]                  set_idx;

  logic                              accept;
  logic                              adv;
  logic                              is_access;
  logic                              clr_done;

  logic                              ram_we, ram_re;
  logic [IDX_W-1:0]                  ram_waddr;
  logic [ROW_W-1:0]                  ram_wdata, ram_rdata;

  salc_pkg::line_t [MAX_WAYS-1:0]    rd_row, wr_row;
  salc_pkg::upd_res_t                upd_res;

  function automatic logic [salc_pkg::TOTAL_W-1:0] sat_inc(
    input logic [salc_pkg::TOTAL_W-1:0] c,
    input logic                         en
  );
    logic [salc_pkg::TOTAL_W-1:0] r;
    r = c;
    if (en && (c != '1)) begin
      r = c + 1'b1;
    end
    return r;
  endfunction

  // effective configuration
  always_comb begin
    int sb_raw;
    int nw_raw;
    sb_raw = (set_bits_q == '0) ? 1 : int'(set_bits_q);
    if (sb_raw > SET_LIM) begin
      sb_raw = SET_LIM;
    end
    sb_eff = salc_pkg::SET_BITS_W'(sb_raw);
    nw_raw = (ways_q == '0) ? 1 : int'(ways_q);
    if (nw_raw > MAX_WAYS) begin
      nw_raw = MAX_WAYS;
    end
    nw_eff = NW_W'(nw_raw);
    bb_eff = (block_bits_q == '0) ? salc_pkg::BLOCK_BITS_W'(1) : block_bits_q;
  end

  // ways in use
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (NW_W'(w) < nw_eff);
    end
  end

  // address split
  assign addr_sh  = address_i >> bb_eff;
  assign tag_full = addr_sh >> sb_eff;
  assign set_idx  = addr_sh[IDX_W-1:0] & ~({IDX_W{1'b1}} << sb_eff);

  // handshake and sequencing
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign adv        = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);
  assign is_access  = (op_q != salc_pkg::OP_FETCH);
  assign clr_done   = (clr_cnt_q == IDX_W'(MAX_SETS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (adv) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_CLEAR) && !clr_done) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= salc_pkg::SET_BITS_RST;
      ways_q       <= salc_pkg::WAYS_RST;
      block_bits_q <= salc_pkg::BLOCK_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        salc_pkg::REG_SET_BITS:   set_bits_q   <= cfg_wdata_i[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::REG_WAYS:       ways_q       <= cfg_wdata_i[salc_pkg::WAYS_W-1:0];
        salc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      tag_q <= tag_full[salc_pkg::TAG_W-1:0];
      set_q <= set_idx;
    end
  end

  // set row memory
  assign ram_re    = accept;
  assign ram_we    = (state_q == ST_CLEAR) || (adv && is_access);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : set_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : wr_row;
  assign rd_row    = ram_rdata;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_idx),
    .rdata_o (ram_rdata)
  );

  // lookup and LRU update of the row
  salc_upd #(
    .MAX_WAYS (MAX_WAYS)
  ) u_upd (
    .row_i    (rd_row),
    .tag_i    (tag_q),
    .in_use_i (in_use),
    .row_o    (wr_row),
    .res_o    (upd_res)
  );

  // running totals, a modify's second access adds one more hit
  always_comb begin
    logic [salc_pkg::TOTAL_W-1:0] h1;
    h1       = sat_inc(hits_q, is_access && upd_res.hit);
    hits_d   = sat_inc(h1, op_q == salc_pkg::OP_MODIFY);
    misses_d = sat_inc(misses_q, is_access && !upd_res.hit);
    evicts_d = sat_inc(evicts_q, is_access && upd_res.evict);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (adv) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      second_q <= (op_q == salc_pkg::OP_MODIFY);
      if (!is_access) begin
        outcome_q <= salc_pkg::OUT_IGNORED;
      end else if (upd_res.hit) begin
        outcome_q <= salc_pkg::OUT_HIT;
      end else if (upd_res.evict) begin
        outcome_q <= salc_pkg::OUT_EVICT;
      end else begin
        outcome_q <= salc_pkg::OUT_MISS;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign second_hit_o     = second_q;
  assign hit_total_o      = hits_q;
  assign miss_total_o     = misses_q;
  assign eviction_total_o = evicts_q;

  // a new result only follows a row lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_LOOKUP)
    else $error("result appeared without a lookup");

  // the row memory is never written while waiting for an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE))
    else $error("row write while idle");

  // a lookup never reports both a hit and an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> !(upd_res.hit && upd_res.evict))
    else $error("hit and eviction together");

  // totals never go down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q))
            && (evicts_q >= $past(evicts_q)))
    else $error("total decreased");

endmodule
